// ===== rtl/core/hkt_pkg.sv =====
// ----------------------------------------------------------------------------
// hkt_pkg
// Types, constants and helpers shared by the hashed key table blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hkt_pkg;

   localparam int SLOTS      = 1024;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int KEY_W      = 64;
   localparam int HALF_W     = 32;
   localparam int SLOT_IDX_W = 10;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 11;
   localparam int LIMIT_W    = 10;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;
   localparam int HASH_STEPS = 7;
   localparam int STEP_W     = $clog2(HASH_STEPS);

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(768);
   localparam logic [HALF_W-1:0]  LOOKUP3_INIT = 32'hdeadbeef + 32'd32;
   localparam logic [STEP_W-1:0]  LAST_STEP    = STEP_W'(HASH_STEPS - 1);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic MODE_OAAT    = 1'b0;
   localparam logic MODE_LOOKUP3 = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_LIMIT = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STAT_FOUND     = 3'd0,
      STAT_INSERTED  = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_ILLEGAL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic illegal;
      logic probe_start;
      logic probe;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_done;
      logic key_zero;
      logic probe_end;
   } sts_type;

   function automatic logic [HALF_W-1:0] rotl32(input logic [HALF_W-1:0] x,
                                                input int unsigned k);
      return (x << k) | (x >> (HALF_W - k));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hkt_if.sv =====
// ----------------------------------------------------------------------------
// hkt_if
// Request, response and register write channels of the hashed key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hkt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [hkt_pkg::KEY_W-1:0] key;

   modport source (output valid, opcode, key, input ready);
   modport sink   (input valid, opcode, key, output ready);
endinterface

interface hkt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hkt_pkg::STATUS_W-1:0]   status;
   logic [hkt_pkg::SLOT_IDX_W-1:0] slot_index;

   modport source (output valid, status, slot_index, input ready);
   modport sink   (input valid, status, slot_index, output ready);
endinterface

interface hkt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hkt_pkg::CSR_IDX_W-1:0]  index;
   logic [hkt_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hkt_hash.sv =====
// ----------------------------------------------------------------------------
// hkt_hash
// Iterative key hash: one-at-a-time over four bytes or lookup3 final mix,
// one step per cycle, seven steps in either mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hkt_hash (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        mode,
   input  logic [hkt_pkg::KEY_W-1:0]   key,
   output logic                        done,
   output logic [hkt_pkg::HALF_W-1:0]  hash
);

   logic [hkt_pkg::HALF_W-1:0] a_ff, a_in;
   logic [hkt_pkg::HALF_W-1:0] b_ff, b_in;
   logic [hkt_pkg::HALF_W-1:0] c_ff, c_in;
   logic [hkt_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       mode_ff, mode_in;
   logic [7:0]                 byte_sel;
   logic [hkt_pkg::HALF_W-1:0] t1;
   logic [hkt_pkg::HALF_W-1:0] t2;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    byte_sel = a_ff[7:0];
         2'd1:    byte_sel = a_ff[15:8];
         2'd2:    byte_sel = a_ff[23:16];
         default: byte_sel = a_ff[31:24];
      endcase
      t1 = c_ff + {24'd0, byte_sel};
      t2 = t1 + (t1 << 10);
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      mode_in = mode_ff;
      if (start) begin
         mode_in = mode;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
         if (mode == hkt_pkg::MODE_LOOKUP3) begin
            a_in = hkt_pkg::LOOKUP3_INIT + key[31:0];
            b_in = hkt_pkg::LOOKUP3_INIT + key[63:32];
            c_in = hkt_pkg::LOOKUP3_INIT;
         end else begin
            a_in = key[31:0];
            b_in = '0;
            c_in = '0;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == hkt_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (mode_ff == hkt_pkg::MODE_LOOKUP3) begin
            case (step_ff)
               3'd0:    c_in = (c_ff ^ b_ff) - hkt_pkg::rotl32(b_ff, 14);
               3'd1:    a_in = (a_ff ^ c_ff) - hkt_pkg::rotl32(c_ff, 11);
               3'd2:    b_in = (b_ff ^ a_ff) - hkt_pkg::rotl32(a_ff, 25);
               3'd3:    c_in = (c_ff ^ b_ff) - hkt_pkg::rotl32(b_ff, 16);
               3'd4:    a_in = (a_ff ^ c_ff) - hkt_pkg::rotl32(c_ff, 4);
               3'd5:    b_in = (b_ff ^ a_ff) - hkt_pkg::rotl32(a_ff, 14);
               3'd6:    c_in = (c_ff ^ b_ff) - hkt_pkg::rotl32(b_ff, 24);
               default: c_in = c_ff;
            endcase
         end else begin
            case (step_ff)
               3'd0, 3'd1, 3'd2, 3'd3: c_in = t2 ^ (t2 >> 6);
               3'd4:    c_in = c_ff + (c_ff << 3);
               3'd5:    c_in = c_ff ^ (c_ff >> 11);
               3'd6:    c_in = c_ff + (c_ff << 15);
               default: c_in = c_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      step_ff <= step_in;
      mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign hash = c_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hkt_dpath.sv =====
// ----------------------------------------------------------------------------
// hkt_dpath
// Key store, probe address and compare, entry count, registers and the
// response holding register of the hashed key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hkt_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  hkt_pkg::cmd_type               cmd,
   output hkt_pkg::sts_type               sts,
   input  logic                           req_opcode,
   input  logic [hkt_pkg::KEY_W-1:0]      req_key,
   input  logic                           csr_we,
   input  logic [hkt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hkt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [hkt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [hkt_pkg::SLOT_IDX_W-1:0] rsp_slot_index
);

   logic [hkt_pkg::KEY_W-1:0]      mem [hkt_pkg::SLOTS];

   logic                           key_mode_ff;
   logic [hkt_pkg::LIMIT_W-1:0]    limit_ff;
   logic                           opcode_ff;
   logic [hkt_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [hkt_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [hkt_pkg::SLOT_BITS-1:0]  addr_ff;
   logic [hkt_pkg::SLOT_BITS-1:0]  rd_addr;
   logic [hkt_pkg::SLOT_BITS-1:0]  probe_n_ff;
   logic [hkt_pkg::SLOT_BITS-1:0]  clr_ff;
   logic [hkt_pkg::KEY_W-1:0]      rd_data_ff;
   hkt_pkg::status_type            res_status_ff, res_status_in;
   logic [hkt_pkg::SLOT_BITS-1:0]  res_slot_ff, res_slot_in;
   logic [hkt_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [hkt_pkg::SLOT_IDX_W-1:0] rsp_slot_ff;

   logic [hkt_pkg::KEY_W-1:0]      key_mask;
   logic [hkt_pkg::KEY_W-1:0]      stored;
   logic                           hit;
   logic                           empty;
   logic                           last;
   logic                           room;
   logic                           do_insert;
   logic                           mem_we;
   logic [hkt_pkg::SLOT_BITS-1:0]  mem_wa;
   logic [hkt_pkg::KEY_W-1:0]      mem_wd;
   logic                           hash_done;
   logic [hkt_pkg::HALF_W-1:0]     hash;

   hkt_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.accept),
      .mode  (key_mode_ff),
      .key   (req_key),
      .done  (hash_done),
      .hash  (hash)
   );

   // 32-bit mode looks at the low word only
   assign key_mask = (key_mode_ff == hkt_pkg::MODE_LOOKUP3) ? {hkt_pkg::KEY_W{1'b1}}
                   : {{hkt_pkg::HALF_W{1'b0}}, {hkt_pkg::HALF_W{1'b1}}};
   assign key_in   = req_key & key_mask;
   assign stored   = rd_data_ff & key_mask;
   assign hit      = (stored == key_ff);
   assign empty    = (stored == '0);
   assign last     = &probe_n_ff;
   assign room     = !(count_ff > hkt_pkg::COUNT_W'(limit_ff));
   assign do_insert = cmd.probe && !hit && empty && (opcode_ff == hkt_pkg::OP_INSERT) && room;

   always_comb begin
      if (cmd.probe_start) begin
         rd_addr = hash[hkt_pkg::SLOT_BITS-1:0];
      end else if (cmd.probe) begin
         rd_addr = addr_ff + 1'b1;
      end else begin
         rd_addr = addr_ff;
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      if (cmd.illegal) begin
         res_status_in = hkt_pkg::STAT_ILLEGAL;
         res_slot_in   = '0;
      end else if (cmd.probe) begin
         res_slot_in = '0;
         if (hit) begin
            res_status_in = hkt_pkg::STAT_FOUND;
            res_slot_in   = addr_ff;
         end else if (empty) begin
            if (opcode_ff == hkt_pkg::OP_LOOKUP) begin
               res_status_in = hkt_pkg::STAT_NOT_FOUND;
            end else if (!room) begin
               res_status_in = hkt_pkg::STAT_FULL;
            end else begin
               res_status_in = hkt_pkg::STAT_INSERTED;
               res_slot_in   = addr_ff;
            end
         end else begin
            res_status_in = (opcode_ff == hkt_pkg::OP_INSERT) ? hkt_pkg::STAT_FULL
                                                              : hkt_pkg::STAT_NOT_FOUND;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert && (count_ff != hkt_pkg::COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign mem_we = cmd.clear || do_insert;
   assign mem_wa = cmd.clear ? clr_ff : addr_ff;
   assign mem_wd = cmd.clear ? '0 : key_ff;

   // key store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         opcode_ff <= req_opcode;
         key_ff    <= key_in;
      end
      if (cmd.probe_start || cmd.probe) begin
         addr_ff <= rd_addr;
      end
      if (cmd.probe_start) begin
         probe_n_ff <= '0;
      end else if (cmd.probe) begin
         probe_n_ff <= probe_n_ff + 1'b1;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= hkt_pkg::SLOT_IDX_W'(res_slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= hkt_pkg::MODE_OAAT;
         limit_ff    <= hkt_pkg::LIMIT_RESET;
         count_ff    <= '0;
         clr_ff      <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               hkt_pkg::REG_KEY_MODE:   key_mode_ff <= csr_wdata[0];
               hkt_pkg::REG_LOAD_LIMIT: limit_ff    <= csr_wdata[hkt_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign sts.clear_last = &clr_ff;
   assign sts.hash_done  = hash_done;
   assign sts.key_zero   = (key_ff == '0);
   assign sts.probe_end  = hit || empty || last;

   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hkt_ctrl
// Sequencer of the hashed key table: clearing pass, accept, hash, probe and
// response hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hkt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  hkt_pkg::sts_type sts,
   output hkt_pkg::cmd_type cmd,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready
);

   hkt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkt_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hkt_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = hkt_pkg::S_IDLE;
            end
         end
         hkt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = hkt_pkg::S_HASH;
            end
         end
         hkt_pkg::S_HASH: begin
            if (sts.key_zero) begin
               cmd.illegal = 1'b1;
               state_in    = hkt_pkg::S_DONE;
            end else if (sts.hash_done) begin
               cmd.probe_start = 1'b1;
               state_in        = hkt_pkg::S_PROBE;
            end
         end
         hkt_pkg::S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.probe_end) begin
               state_in = hkt_pkg::S_DONE;
            end
         end
         hkt_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = hkt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hkt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hashed_key_table_find_insert.sv =====
// ----------------------------------------------------------------------------
// hashed_key_table_find_insert
// Open-addressed key table with linear probing, lookup and lookup-or-insert.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              beat
//  req_ch   in   req_ch.valid/ready     opcode, key
//  rsp_ch   out  rsp_ch.valid/ready     status, slot_index
//  csr_ch   in   csr_ch.valid/ready     index, wdata (always ready)
//
//  one request at a time: the key is hashed by the iterative hash, then
//  the slots are probed in turn, each probed slot being one read of the
//  key store read port
//  a zero key is answered as illegal without waiting for the hash or probe
//  after reset a clearing pass writes all SLOTS (1024) slots before req is ready
//  a waiting response sits in its output register while the next beat is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hashed_key_table_find_insert (
   input  logic        clock,
   input  logic        reset,
   hkt_req_if.sink     req_ch,
   hkt_rsp_if.source   rsp_ch,
   hkt_csr_if.sink     csr_ch
);

   hkt_pkg::cmd_type cmd;
   hkt_pkg::sts_type sts;

   assign csr_ch.ready = 1'b1;

   hkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

   hkt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_ch.opcode),
      .req_key        (req_ch.key),
      .csr_we         (csr_ch.valid && csr_ch.ready),
      .csr_index      (csr_ch.index),
      .csr_wdata      (csr_ch.wdata),
      .rsp_status     (rsp_ch.status),
      .rsp_slot_index (rsp_ch.slot_index)
   );

   // no request is taken while the store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ch.ready)
      else $error("request ready during clearing pass");

   // a new response never overwrites one that is still waiting
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response register overwritten");

   // one request in flight: ready drops right after an accepted beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ch.ready)
      else $error("second request taken while busy");

   // a probe never starts without a finished hash
   a_probe_after_hash: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_start |-> sts.hash_done)
      else $error("probe started before hash done");

endmodule

`default_nettype wire

// ===== test/hashed_key_table_find_insert_checker.sv =====
// ----------------------------------------------------------------------------
// hashed_key_table_find_insert_checker
// Watches the request, response and register channels of the key table. Keeps
// its own copy of the key slots, entry count and settings, works out the
// answer to each accepted request and compares it with the response beats in
// order. Mismatches, the answers still owed and the entry count go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_key_table_find_insert_checker (
   input  logic clock,
   input  logic reset,
   hkt_req_if   req_ch,
   hkt_rsp_if   rsp_ch,
   hkt_csr_if   csr_ch,
   output int   mismatches,
   output int   outstanding,
   output int   stored_keys
);
   import hkt_pkg::*;

   typedef struct packed {
      status_type              status;
      logic [SLOT_IDX_W-1:0]   slot;
   } answer_type;

   logic [KEY_W-1:0]   slot_keys [SLOTS];
   logic [COUNT_W-1:0] live_entries;
   logic               wide_keys;
   logic [LIMIT_W-1:0] fill_limit;
   answer_type         pending_answers [$];
   int                 fault_total;

   function automatic logic [HALF_W-1:0] rotl(input logic [HALF_W-1:0] x, input int n);
      logic [2*HALF_W-1:0] twice;
      twice = {x, x} << n;
      return twice[2*HALF_W-1:HALF_W];
   endfunction

   function automatic logic [HALF_W-1:0] oaat_hash(input logic [HALF_W-1:0] k);
      logic [HALF_W-1:0] h;
      h = '0;
      for (int i = 0; i < 4; i++) begin
         h = h + k[8*i +: 8];
         h = h + (h << 10);
         h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

   function automatic logic [HALF_W-1:0] mix_lookup3(input logic [KEY_W-1:0] k);
      logic [HALF_W-1:0] a;
      logic [HALF_W-1:0] b;
      logic [HALF_W-1:0] c;
      a = LOOKUP3_INIT + k[HALF_W-1:0];
      b = LOOKUP3_INIT + k[KEY_W-1:HALF_W];
      c = LOOKUP3_INIT;
      c = (c ^ b) - rotl(b, 14);
      a = (a ^ c) - rotl(c, 11);
      b = (b ^ a) - rotl(a, 25);
      c = (c ^ b) - rotl(b, 16);
      a = (a ^ c) - rotl(c, 4);
      b = (b ^ a) - rotl(a, 14);
      c = (c ^ b) - rotl(b, 24);
      return c;
   endfunction

   function automatic answer_type probe_table(input logic op, input logic [KEY_W-1:0] raw_key);
      logic [KEY_W-1:0]     keep;
      logic [KEY_W-1:0]     k;
      logic [KEY_W-1:0]     held;
      logic [HALF_W-1:0]    start;
      logic [SLOT_BITS-1:0] s;
      answer_type           res;
      bit                   done;
      keep = (wide_keys == MODE_LOOKUP3) ? '1 : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
      k = raw_key & keep;
      res.status = STAT_ILLEGAL;
      res.slot = '0;
      if (k == '0) return res;
      start = (wide_keys == MODE_LOOKUP3) ? mix_lookup3(k) : oaat_hash(k[HALF_W-1:0]);
      s = start[SLOT_BITS-1:0];
      res.status = (op == OP_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
      done = 1'b0;
      for (int n = 0; n < SLOTS && !done; n++) begin
         held = slot_keys[s] & keep;
         if (held == k) begin
            res.status = STAT_FOUND;
            res.slot = SLOT_IDX_W'(s);
            done = 1'b1;
         end else if (held == '0) begin
            done = 1'b1;
            if (op != OP_INSERT) begin
               res.status = STAT_NOT_FOUND;
            end else if (live_entries > fill_limit) begin
               res.status = STAT_FULL;
            end else begin
               slot_keys[s] = k;
               if (live_entries != COUNT_MAX) live_entries = live_entries + 1'b1;
               res.status = STAT_INSERTED;
               res.slot = SLOT_IDX_W'(s);
            end
         end
         s = s + 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_keys[i] = '0;
         live_entries = '0;
         wide_keys = MODE_OAAT;
         fill_limit = LIMIT_RESET;
         pending_answers.delete();
         fault_total = 0;
      end else begin
         // the older answer leaves before a new request is taken on this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               if (fault_total < 10)
                  $display("unexpected response beat: status %0d slot %0d",
                           rsp_ch.status, rsp_ch.slot_index);
               fault_total++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.slot_index !== want.slot) begin
                  if (fault_total < 10)
                     $display("response mismatch: status %0d slot %0d, expected %0d slot %0d",
                              rsp_ch.status, rsp_ch.slot_index, want.status, want.slot);
                  fault_total++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_KEY_MODE: begin
                  wide_keys = csr_ch.wdata[0];
               end
               REG_LOAD_LIMIT: begin
                  fill_limit = csr_ch.wdata[LIMIT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            pending_answers.push_back(probe_table(req_ch.opcode, req_ch.key));
      end
      mismatches <= fault_total;
      outstanding <= pending_answers.size();
      stored_keys <= int'(live_entries);
   end

endmodule

// ===== test/hashed_key_table_find_insert_test.sv =====
// ----------------------------------------------------------------------------
// hashed_key_table_find_insert_test
// Drives lookups and lookup-or-inserts into the key table under both key
// modes and a range of load limits, with random idling on both channels and a
// long response hold-off. Ends by filling every slot and probing the full
// table. The checker beside the block predicts and compares the answers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_key_table_find_insert_test;
   import hkt_pkg::*;

   localparam int CLOCK_HALF      = 10;
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 200;
   localparam int POOL_DEPTH      = 64;
   localparam int PROBE_ROUNDS    = 4;
   localparam logic [LIMIT_W-1:0]   LIMIT_MAX    = {LIMIT_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TOP_IDX  = {CSR_IDX_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkt_req_if req_ch ();
   hkt_rsp_if rsp_ch ();
   hkt_csr_if csr_ch ();

   int mismatches;
   int outstanding;
   int stored_keys;
   int quiet_cycles = 0;
   int sent_items = 0;
   logic cur_mode = MODE_OAAT;
   logic [KEY_W-1:0] recent_keys [$];

   hashed_key_table_find_insert dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   hashed_key_table_find_insert_checker slot_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .stored_keys (stored_keys)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = {$urandom(), $urandom()};
      if (k[HALF_W-1:0] == '0) k[0] = 1'b1;
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      // zero keys; in 32-bit mode the high word alone does not save them
      if (roll < 4) return (cur_mode == MODE_OAAT) ? {$urandom(), 32'h0} : '0;
      if (roll < 50 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      return fresh_key();
   endfunction

   task automatic send_request(input logic op, input logic [KEY_W-1:0] k);
      int gap;
      gap = ((sent_items / 40) % 5 == 4) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.key    <= k;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent_items++;
      if (k[HALF_W-1:0] != '0) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > POOL_DEPTH) void'(recent_keys.pop_front());
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic mode, input logic [LIMIT_W-1:0] limit);
      settle();
      write_register(REG_KEY_MODE, CSR_DATA_W'(mode));
      write_register(REG_LOAD_LIMIT, CSR_DATA_W'(limit));
      cur_mode = mode;
   endtask

   task automatic run_phase(input logic mode, input logic [LIMIT_W-1:0] limit);
      configure(mode, limit);
      repeat (PHASE_ITEMS)
         send_request($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, pick_key());
   endtask

   // response side, with one long hold-off now and then to back up the block
   initial begin
      int stall;
      int beats;
      beats = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ((beats / 50) % 5 == 3) ? 0 : $urandom_range(0, 9);
         if (beats == 300 || beats == 900) stall = HOLD_OFF_CYCLES;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
         beats++;
      end
   end

   initial begin
      logic [KEY_W-1:0] k;
      int fill_count;
      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_LOOKUP;
      req_ch.key    = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = REG_KEY_MODE;
      csr_ch.wdata  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, 32-bit keys
      send_request(OP_LOOKUP, 64'h0);
      send_request(OP_INSERT, 64'h0);
      send_request(OP_INSERT, 64'hffff_ffff_0000_0000);
      send_request(OP_LOOKUP, 64'h1);
      send_request(OP_INSERT, 64'h1);
      send_request(OP_LOOKUP, 64'h1);
      send_request(OP_INSERT, 64'h1);
      send_request(OP_INSERT, 64'hffff_ffff_ffff_ffff);
      send_request(OP_LOOKUP, 64'h0000_0000_ffff_ffff);
      send_request(OP_INSERT, 64'h8000_0000);
      send_request(OP_INSERT, 64'h1234_5678_9abc_def0);

      // load limit below the count: new keys refused, hits still found
      configure(MODE_OAAT, '0);
      send_request(OP_INSERT, 64'h2222);
      send_request(OP_LOOKUP, 64'h1);
      send_request(OP_INSERT, 64'h8000_0000);

      // writes past the register list, and mode with unused data bits set
      settle();
      write_register(REG_TOP_IDX, '1);
      write_register(REG_PAST_END, '0);
      write_register(REG_KEY_MODE, '1);
      write_register(REG_LOAD_LIMIT, CSR_DATA_W'(LIMIT_MAX));
      cur_mode = MODE_LOOKUP3;
      send_request(OP_LOOKUP, 64'h1);
      send_request(OP_INSERT, 64'hffff_ffff_ffff_ffff);
      send_request(OP_INSERT, 64'h8000_0000_0000_0001);
      send_request(OP_LOOKUP, 64'h8000_0000_0000_0001);
      send_request(OP_LOOKUP, 64'h0);
      send_request(OP_LOOKUP, 64'h0000_0001_0000_0000);

      // back to 32-bit keys: stored wide keys match on their low word
      settle();
      write_register(REG_KEY_MODE, CSR_DATA_W'(2));
      cur_mode = MODE_OAAT;
      send_request(OP_LOOKUP, 64'h1234_ffff_ffff);
      send_request(OP_INSERT, 64'habcd_0000_8000_0001);

      run_phase(MODE_OAAT, 10'd768);
      run_phase(MODE_LOOKUP3, LIMIT_MAX);
      run_phase(MODE_OAAT, 10'd1);
      run_phase(MODE_LOOKUP3, 10'd400);
      run_phase(MODE_OAAT, LIMIT_MAX);
      run_phase(MODE_LOOKUP3, '0);

      // fill every slot; a few wide keys with a zero low word look empty later
      configure(MODE_LOOKUP3, LIMIT_MAX);
      fill_count = 0;
      while (stored_keys < SLOTS) begin
         fill_count++;
         k = fresh_key();
         if (fill_count % 64 == 0) begin
            k[HALF_W-1:0] = '0;
            k[KEY_W-1] = 1'b1;
         end
         send_request(OP_INSERT, k);
      end

      // no empty slot left for wide keys
      repeat (PROBE_ROUNDS) begin
         send_request(OP_LOOKUP, fresh_key());
         send_request(OP_INSERT, fresh_key());
         send_request(OP_LOOKUP, recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
      end

      // 32-bit view of the full table
      configure(MODE_OAAT, LIMIT_MAX);
      repeat (PROBE_ROUNDS) begin
         send_request(OP_LOOKUP, fresh_key());
         send_request(OP_INSERT, fresh_key());
         send_request(OP_LOOKUP, recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
      end

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/hkt_pkg.sv
rtl/core/hkt_if.sv
rtl/core/hkt_hash.sv
rtl/core/hkt_dpath.sv
rtl/core/hkt_ctrl.sv
rtl/core/hashed_key_table_find_insert.sv
test/hashed_key_table_find_insert_checker.sv
test/hashed_key_table_find_insert_test.sv
